[rtl/core/gpe_pkg.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial extended Euclid: shared definitions
// Types and constants used by the inverse unit and its sub-blocks.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int unsigned PolyBitsDef = 16;
  localparam int unsigned FieldW      = 16;

  typedef enum logic [2:0] {
    StIdle,
    StNorm,
    StDiv,
    StDenorm,
    StDone
  } gpe_state_e;

  typedef struct packed {
    logic load;
    logic norm_step;
    logic div_step;
    logic swap;
    logic denorm_step;
  } gpe_ctl_t;

  typedef struct packed {
    logic den_top;
    logic div_more;
    logic rem_zero;
    logic den_aligned;
  } gpe_sts_t;

endpackage

[rtl/core/gpe_div_unit.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial extended Euclid: remainder datapath
// Holds the dividend and divisor left-justified with their degree cursors and
// performs one shift-and-xor long division step per cycle.
// ----------------------------------------------------------------------------
module gpe_div_unit #(
  parameter int unsigned PolyBits = gpe_pkg::PolyBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gpe_pkg::gpe_ctl_t    ctl_i,
  input  logic [PolyBits-1:0]  a_i,
  input  logic [PolyBits-1:0]  b_i,
  output gpe_pkg::gpe_sts_t    sts_o,
  output logic                 qbit_o,
  output logic [PolyBits-1:0]  gcd_o
);

  localparam int unsigned CW = $clog2(PolyBits + 1);

  logic [PolyBits-1:0] num_q, num_d;
  logic [PolyBits-1:0] den_q, den_d;
  logic [CW-1:0]       dnp_q, dnp_d;
  logic [CW-1:0]       ddp_q, ddp_d;
  logic [PolyBits-1:0] num_x;

  assign qbit_o = num_q[PolyBits-1];
  assign num_x  = num_q ^ (qbit_o ? den_q : '0);

  always_comb begin
    num_d = num_q;
    den_d = den_q;
    dnp_d = dnp_q;
    ddp_d = ddp_q;
    if (ctl_i.load) begin
      num_d = a_i;
      den_d = b_i;
      dnp_d = CW'(PolyBits);
      ddp_d = CW'(PolyBits);
    end else if (ctl_i.norm_step) begin
      den_d = {den_q[PolyBits-2:0], 1'b0};
      ddp_d = ddp_q - CW'(1);
    end else if (ctl_i.div_step) begin
      num_d = {num_x[PolyBits-2:0], 1'b0};
      dnp_d = dnp_q - CW'(1);
    end else if (ctl_i.swap) begin
      num_d = den_q;
      dnp_d = ddp_q;
      den_d = num_q;
      ddp_d = dnp_q;
    end else if (ctl_i.denorm_step) begin
      den_d = {1'b0, den_q[PolyBits-1:1]};
      ddp_d = ddp_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dnp_q <= CW'(PolyBits);
      ddp_q <= CW'(PolyBits);
    end else begin
      dnp_q <= dnp_d;
      ddp_q <= ddp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
  end

  assign sts_o.den_top     = den_q[PolyBits-1];
  assign sts_o.div_more    = (dnp_q >= ddp_q);
  assign sts_o.rem_zero    = (num_q == '0);
  assign sts_o.den_aligned = (ddp_q == CW'(PolyBits));
  assign gcd_o             = den_q;

`ifndef NO_ASSERTIONS
  a_norm_den_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.norm_step |-> (den_q != '0))
    else $error("Divisor normalisation started on a zero divisor.");

  a_swap_cursor_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.swap |=> (ddp_q < dnp_q))
    else $error("New divisor degree is not below the new dividend degree.");
`endif

endmodule

[rtl/core/gpe_coef_unit.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial extended Euclid: Bezout coefficient datapath
// Accumulates the quotient times the current coefficients bit-serially and
// rotates the coefficient pairs at each remainder step.
// ----------------------------------------------------------------------------
module gpe_coef_unit #(
  parameter int unsigned PolyBits = gpe_pkg::PolyBitsDef
) (
  input  logic                 clk_i,
  input  gpe_pkg::gpe_ctl_t    ctl_i,
  input  logic                 qbit_i,
  output logic [PolyBits-1:0]  coef_a_o,
  output logic [PolyBits-1:0]  coef_b_o
);

  logic [PolyBits-1:0] s0_q, s0_d, s1_q, s1_d;
  logic [PolyBits-1:0] t0_q, t0_d, t1_q, t1_d;
  logic [PolyBits-1:0] acc_s_q, acc_s_d, acc_t_q, acc_t_d;

  always_comb begin
    s0_d    = s0_q;
    s1_d    = s1_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    acc_s_d = acc_s_q;
    acc_t_d = acc_t_q;
    if (ctl_i.load) begin
      s0_d    = PolyBits'(1);
      s1_d    = '0;
      t0_d    = '0;
      t1_d    = PolyBits'(1);
      acc_s_d = '0;
      acc_t_d = '0;
    end else if (ctl_i.div_step) begin
      acc_s_d = {acc_s_q[PolyBits-2:0], 1'b0} ^ (qbit_i ? s1_q : '0);
      acc_t_d = {acc_t_q[PolyBits-2:0], 1'b0} ^ (qbit_i ? t1_q : '0);
    end else if (ctl_i.swap) begin
      s0_d    = s1_q;
      s1_d    = s0_q ^ acc_s_q;
      t0_d    = t1_q;
      t1_d    = t0_q ^ acc_t_q;
      acc_s_d = '0;
      acc_t_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q    <= s0_d;
    s1_q    <= s1_d;
    t0_q    <= t0_d;
    t1_q    <= t1_d;
    acc_s_q <= acc_s_d;
    acc_t_q <= acc_t_d;
  end

  assign coef_a_o = s1_q;
  assign coef_b_o = t1_q;

endmodule

[rtl/core/gpe_ctrl.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial extended Euclid: sequencer
// Steps the datapaths through normalisation, division, remainder swap and
// final alignment of the gcd.
// ----------------------------------------------------------------------------
module gpe_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               b_zero_i,
  input  logic               out_free_i,
  input  gpe_pkg::gpe_sts_t  sts_i,
  output gpe_pkg::gpe_ctl_t  ctl_o,
  output logic               in_ready_o,
  output logic               out_load_o,
  output logic               zdiv_o
);

  gpe_pkg::gpe_state_e state_q, state_d;
  logic                zdiv_q, zdiv_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      gpe_pkg::StIdle: begin
        if (in_valid_i) begin
          state_d = b_zero_i ? gpe_pkg::StDone : gpe_pkg::StNorm;
        end
      end
      gpe_pkg::StNorm: begin
        if (sts_i.den_top) begin
          state_d = gpe_pkg::StDiv;
        end
      end
      gpe_pkg::StDiv: begin
        if (!sts_i.div_more) begin
          state_d = sts_i.rem_zero ? gpe_pkg::StDenorm : gpe_pkg::StNorm;
        end
      end
      gpe_pkg::StDenorm: begin
        if (sts_i.den_aligned) begin
          state_d = gpe_pkg::StDone;
        end
      end
      gpe_pkg::StDone: begin
        if (out_free_i) begin
          state_d = gpe_pkg::StIdle;
        end
      end
      default: state_d = gpe_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctl_o      = '0;
    in_ready_o = 1'b0;
    out_load_o = 1'b0;
    zdiv_d     = zdiv_q;
    unique case (state_q)
      gpe_pkg::StIdle: begin
        in_ready_o = 1'b1;
        ctl_o.load = in_valid_i;
        if (in_valid_i) begin
          zdiv_d = b_zero_i;
        end
      end
      gpe_pkg::StNorm:   ctl_o.norm_step   = !sts_i.den_top;
      gpe_pkg::StDiv: begin
        ctl_o.div_step = sts_i.div_more;
        ctl_o.swap     = !sts_i.div_more && !sts_i.rem_zero;
      end
      gpe_pkg::StDenorm: ctl_o.denorm_step = !sts_i.den_aligned;
      gpe_pkg::StDone:   out_load_o        = out_free_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gpe_pkg::StIdle;
      zdiv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      zdiv_q  <= zdiv_d;
    end
  end

  assign zdiv_o = zdiv_q;

`ifndef NO_ASSERTIONS
  a_done_gcd_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gpe_pkg::StDone && !zdiv_q) |-> sts_i.den_aligned)
    else $error("Result offered before the gcd was realigned.");
`endif

endmodule

[rtl/core/gf2_poly_ext_euclid_inverse_unit.sv]
// ----------------------------------------------------------------------------
// GF(2) polynomial extended Euclid inverse unit
// Returns the Bezout coefficients and the gcd of two binary polynomials.
// ----------------------------------------------------------------------------
// The unit takes one transaction at a time and answers each with exactly one
// result transaction. Coefficient of a, coefficient of b and the gcd satisfy
// a*coef_a + b*coef_b = gcd over GF(2); when the gcd is 1, coef_a is the
// inverse of a modulo b. A zero b gives all-zero fields with tuser set. How
// long an item with a nonzero b occupies the unit depends on the degree of
// the gcd and on the number of long divisions of the Euclid run. The
// divisor and dividend pass through a one-bit-a-cycle shift-and-xor datapath
// with a matching bit-serial coefficient multiplier. A finished result is
// held in the output register, so the next transaction is taken while the
// previous result still waits; a result can only be held up if the one
// before it has not left.
// ----------------------------------------------------------------------------
module gf2_poly_ext_euclid_inverse_unit #(
  parameter int unsigned PolyBits = gpe_pkg::PolyBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,  // a_poly, b_poly
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // coef_a, coef_b, gcd_poly
  output logic        m_axis_tuser   // zero_divisor
);

  localparam int unsigned FW = gpe_pkg::FieldW;
  localparam int unsigned XW = (PolyBits > FW) ? PolyBits : FW;

  logic [XW-1:0]       a_x, b_x;
  logic [PolyBits-1:0] a_w, b_w;
  logic                b_zero;

  gpe_pkg::gpe_ctl_t   ctl;
  gpe_pkg::gpe_sts_t   sts;
  logic                qbit;
  logic [PolyBits-1:0] gcd, coef_a, coef_b;
  logic [XW-1:0]       gcd_x, coef_a_x, coef_b_x;
  logic                out_free, out_load, zdiv;

  logic                m_valid_q, m_valid_d;
  logic [47:0]         m_data_q, m_data_d;
  logic                m_user_q, m_user_d;

  assign a_x    = XW'(s_axis_tdata[FW-1:0]);
  assign b_x    = XW'(s_axis_tdata[2*FW-1:FW]);
  assign a_w    = a_x[PolyBits-1:0];
  assign b_w    = b_x[PolyBits-1:0];
  assign b_zero = (b_w == '0);

  gpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .b_zero_i   (b_zero),
    .out_free_i (out_free),
    .sts_i      (sts),
    .ctl_o      (ctl),
    .in_ready_o (s_axis_tready),
    .out_load_o (out_load),
    .zdiv_o     (zdiv)
  );

  gpe_div_unit #(
    .PolyBits (PolyBits)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .a_i    (a_w),
    .b_i    (b_w),
    .sts_o  (sts),
    .qbit_o (qbit),
    .gcd_o  (gcd)
  );

  gpe_coef_unit #(
    .PolyBits (PolyBits)
  ) u_coef (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .qbit_i   (qbit),
    .coef_a_o (coef_a),
    .coef_b_o (coef_b)
  );

  assign coef_a_x = XW'(coef_a);
  assign coef_b_x = XW'(coef_b);
  assign gcd_x    = XW'(gcd);
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    if (out_load) begin
      m_valid_d = 1'b1;
      m_user_d  = zdiv;
      if (zdiv) begin
        m_data_d = '0;
      end else begin
        m_data_d = {gcd_x[FW-1:0], coef_b_x[FW-1:0], coef_a_x[FW-1:0]};
      end
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

endmodule

[sim/gf2_poly_ext_euclid_inverse_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the GF(2) polynomial extended Euclid inverse unit
// A table of directed polynomial pairs is sent first, then random pairs in
// phases with different amounts of idling on the input and stalling on the
// output. Every result transaction is compared with the expected Bezout
// coefficients and gcd, from the table for fixed rows, else worked out here.
// ----------------------------------------------------------------------------
module gf2_poly_ext_euclid_inverse_unit_tb;

  localparam int unsigned PolyBits     = gpe_pkg::PolyBitsDef;
  localparam int unsigned NumDirRows   = 16;
  localparam int unsigned ItemsPerPhase = 470;
  localparam int unsigned RxHoldCycles = 800;
  localparam int unsigned TailCycles   = 400;

  typedef struct packed {
    logic [15:0] coef_a;
    logic [15:0] coef_b;
    logic [15:0] gcd_poly;
    logic        zero_div;
  } bezout_t;

  typedef struct packed {
    logic [15:0] a_poly;
    logic [15:0] b_poly;
    logic        fixed;
    bezout_t     res;
  } dir_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // a_poly, b_poly
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // coef_a, coef_b, gcd_poly
  logic        m_axis_tuser;   // zero_divisor

  bezout_t     pending_results [$];
  int unsigned mismatch_cnt;
  int unsigned send_idle_pct;
  int unsigned rx_stall_pct;
  logic        hold_req;

  dir_row_t dir_rows [NumDirRows] = '{
    '{16'h0000, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{16'hFFFF, 16'h0000, 1'b1, '{16'h0000, 16'h0000, 16'h0000, 1'b1}},
    '{16'h0000, 16'hFFFF, 1'b1, '{16'h0000, 16'h0001, 16'hFFFF, 1'b0}},
    '{16'hFFFF, 16'hFFFF, 1'b1, '{16'h0000, 16'h0001, 16'hFFFF, 1'b0}},
    '{16'h0001, 16'h0001, 1'b1, '{16'h0000, 16'h0001, 16'h0001, 1'b0}},
    '{16'h8000, 16'h0001, 1'b1, '{16'h0000, 16'h0001, 16'h0001, 1'b0}},
    '{16'hFFFF, 16'h0001, 1'b1, '{16'h0000, 16'h0001, 16'h0001, 1'b0}},
    '{16'h8001, 16'h0003, 1'b1, '{16'h0000, 16'h0001, 16'h0003, 1'b0}},
    '{16'h0001, 16'hFFFF, 1'b0, '0},
    '{16'h0053, 16'h011B, 1'b0, '0},
    '{16'h8000, 16'h8001, 1'b0, '0},
    '{16'hAAAA, 16'h5555, 1'b0, '0},
    '{16'h1234, 16'h8000, 1'b0, '0},
    '{16'h0002, 16'h8000, 1'b0, '0},
    '{16'hFFFF, 16'h8000, 1'b0, '0},
    '{16'h0001, 16'h8000, 1'b0, '0}
  };

  gf2_poly_ext_euclid_inverse_unit #(
    .PolyBits(PolyBits)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic int poly_deg(logic [31:0] p);
    int d;
    d = -1;
    for (int k = 0; k < 32; k++) begin
      if (p[k]) d = k;
    end
    return d;
  endfunction

  function automatic logic [31:0] clmul16(logic [15:0] m, logic [15:0] n);
    logic [31:0] acc;
    acc = '0;
    for (int k = 0; k < PolyBits; k++) begin
      if (n[k]) acc = acc ^ ({16'h0000, m} << k);
    end
    return acc;
  endfunction

  function automatic void poly_divmod(input logic [15:0] num, input logic [15:0] den,
                                      output logic [15:0] quo, output logic [15:0] rem);
    int dd;
    int sh;
    dd  = poly_deg({16'h0000, den});
    quo = '0;
    rem = num;
    while (rem != '0 && poly_deg({16'h0000, rem}) >= dd) begin
      sh      = poly_deg({16'h0000, rem}) - dd;
      quo[sh] = 1'b1;
      rem     = rem ^ (den << sh);
    end
  endfunction

  function automatic bezout_t ext_euclid_expect(logic [15:0] a_in, logic [15:0] b_in);
    logic [15:0] a, b, q, r, s0, s1, t0, t1, sn, tn;
    logic [31:0] prod;
    bezout_t     res;
    a = a_in;
    b = b_in;
    if (b == '0) begin
      res = '{16'h0000, 16'h0000, 16'h0000, 1'b1};
      return res;
    end
    s0 = 16'h0001;
    t0 = 16'h0000;
    s1 = 16'h0000;
    t1 = 16'h0001;
    poly_divmod(a, b, q, r);
    for (int g = 0; g <= 2 * PolyBits + 2 && r != '0; g++) begin
      prod = clmul16(q, s1);
      sn   = s0 ^ prod[15:0];
      prod = clmul16(q, t1);
      tn   = t0 ^ prod[15:0];
      s0   = s1;
      s1   = sn;
      t0   = t1;
      t1   = tn;
      a    = b;
      b    = r;
      poly_divmod(a, b, q, r);
    end
    res = '{s1, t1, b, 1'b0};
    return res;
  endfunction

  function automatic logic [31:0] pick_poly_pair();
    logic [15:0] a, b, mask_a, mask_b;
    logic [31:0] prod;
    int unsigned kind;
    kind = $urandom_range(0, 99);
    a    = 16'($urandom_range(0, 16'hFFFF));
    b    = 16'($urandom_range(0, 16'hFFFF));
    if (kind < 5) begin
      b = '0;
    end else if (kind < 15) begin
      b    = 16'($urandom_range(1, 255));
      prod = clmul16(b, 16'($urandom_range(0, 255)));
      a    = prod[15:0];
    end else if (kind < 20) begin
      a = b;
    end else if (kind < 50) begin
      mask_a = 16'((32'd1 << $urandom_range(1, 16)) - 1);
      mask_b = 16'((32'd1 << $urandom_range(1, 16)) - 1);
      a      = a & mask_a;
      b      = b & mask_b;
    end
    return {b, a};
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_poly_pair(input logic [15:0] a, input logic [15:0] b,
                                input logic fixed, input bezout_t typed_res);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b, a};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(fixed ? typed_res : ext_euclid_expect(a, b));
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (RxHoldCycles - 1) @(negedge clk_i);
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    bezout_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32], m_axis_tuser};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: s=%h t=%h g=%h zd=%b",
                                  got.coef_a, got.coef_b, got.gcd_poly, got.zero_div));
      end else begin
        want = pending_results.pop_front();
        if (got.coef_a !== want.coef_a)
          report_mismatch($sformatf("coef_a exp %h got %h", want.coef_a, got.coef_a));
        if (got.coef_b !== want.coef_b)
          report_mismatch($sformatf("coef_b exp %h got %h", want.coef_b, got.coef_b));
        if (got.gcd_poly !== want.gcd_poly)
          report_mismatch($sformatf("gcd_poly exp %h got %h", want.gcd_poly, got.gcd_poly));
        if (got.zero_div !== want.zero_div)
          report_mismatch($sformatf("zero_divisor exp %b got %b",
                                    want.zero_div, got.zero_div));
      end
    end
  end

  initial begin
    #25000000;
    $display("gf2_poly_ext_euclid_inverse_unit test failed");
    $finish;
  end

  initial begin
    logic [31:0] pair;
    int unsigned idle_sets [4][2];
    idle_sets     = '{'{0, 0}, '{45, 0}, '{0, 45}, '{15, 15}};
    mismatch_cnt  = 0;
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_req      = 1'b0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirRows; i++) begin
      send_poly_pair(dir_rows[i].a_poly, dir_rows[i].b_poly, dir_rows[i].fixed,
                     dir_rows[i].res);
    end
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = idle_sets[ph][0];
      rx_stall_pct  = idle_sets[ph][1];
      if (ph == 0 || ph == 2) begin
        @(posedge clk_i);
        hold_req = 1'b1;
        @(negedge clk_i);
      end
      for (int n = 0; n < ItemsPerPhase; n++) begin
        pair = pick_poly_pair();
        send_poly_pair(pair[15:0], pair[31:16], 1'b0, '0);
      end
      drain_results();
    end

    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
    if (mismatch_cnt == 0) begin
      $display("gf2_poly_ext_euclid_inverse_unit test passed");
    end else begin
      $display("gf2_poly_ext_euclid_inverse_unit test failed");
    end
    $finish;
  end

endmodule
